/* rtl/core/tdp_pkg.sv */
// Package for the trial-division prime test block.
// Holds field widths, parameter defaults and the divider status type.
// No dependencies.
`timescale 1ns / 1ps

package tdp_pkg;

  // Fixed widths of the channel fields
  localparam int CANDIDATE_W = 32;
  localparam int TESTED_W    = 32;

  // Default arithmetic width of the tested number
  localparam int NUMBER_WIDTH_DEF = 32;

  // Status returned by the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/core/tdp_in_if.sv */
// Input channel interface: valid/ready handshake with the candidate payload.
// Depends on tdp_pkg for the field width.
`timescale 1ns / 1ps

interface tdp_in_if import tdp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CANDIDATE_W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

/* rtl/core/tdp_out_if.sv */
// Result channel interface: valid/ready handshake with tested value and flag.
// Depends on tdp_pkg for the field width.
`timescale 1ns / 1ps

interface tdp_out_if import tdp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TESTED_W-1:0] tested_value;
  logic                is_prime;

  modport source (output valid, output tested_value, output is_prime, input ready);
  modport sink   (input valid, input tested_value, input is_prime, output ready);
endinterface

/* rtl/core/tdp_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all trial divisors.
// Depends on tdp_pkg for the status struct.
`timescale 1ns / 1ps

module tdp_div import tdp_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] dividend,
  input  logic [NUMBER_WIDTH-1:0] divisor,
  output logic [NUMBER_WIDTH-1:0] quotient,
  output logic [NUMBER_WIDTH-1:0] remainder,
  output div_stat_t               stat
);

  localparam int W  = NUMBER_WIDTH;
  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;

  logic [W:0]    shifted_nxt;
  logic [W:0]    diff_nxt;
  logic          ge_nxt;
  logic [W-1:0]  rem_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted_nxt = {rem_r, quo_r[W-1]};
    diff_nxt    = shifted_nxt - {1'b0, dvs_r};
    ge_nxt      = (shifted_nxt >= {1'b0, dvs_r});
    rem_nxt     = ge_nxt ? diff_nxt[W-1:0] : shifted_nxt[W-1:0];
  end

  // Sequence control: count W steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[W-2:0], ge_nxt};
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* rtl/core/trial_division_prime_test_top.sv */
// Top level of the trial-division prime test: sequencer around one divider.
// Depends on tdp_pkg, tdp_in_if, tdp_out_if and tdp_div.
//
//   channel  dir  payload                    transaction
//   in_ch    in   candidate[31:0]            valid & ready
//   out_ch   out  tested_value[31:0],        valid & ready
//                 is_prime
//
// Inputs below 4 skip the divider. Otherwise divisors d = 2, 3, ... are
// tried until d exceeds n / d or divides n; each try is one run of the
// shared restoring divider (S_START, then S_DIV until it signals done).
// in_ch.ready is high only while no item is in work. A finished result
// waits in the output register; the block can take the next item meanwhile.
// Synchronous active-low reset clears the sequencer, the held number, the
// trial divisor and the output valid.
`timescale 1ns / 1ps

module trial_division_prime_test_top import tdp_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  tdp_in_if.sink   in_ch,
  tdp_out_if.source out_ch
);

  localparam int W  = NUMBER_WIDTH;
  localparam int LW = (W < CANDIDATE_W) ? W : CANDIDATE_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]          state_r;
  logic [1:0]          state_nxt;
  logic [W-1:0]        num_r;
  logic [W-1:0]        num_nxt;
  logic [W-1:0]        div_r;
  logic [W-1:0]        div_nxt;
  logic                prime_r;
  logic                prime_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [TESTED_W-1:0] out_value_r;
  logic                out_prime_r;
  logic                load_out;

  logic                in_accept;
  logic [W-1:0]        quotient;
  logic [W-1:0]        remainder;
  div_stat_t           div_stat;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // Shared divider: n / d and n % d for the current trial divisor
  tdp_div #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == S_START),
    .dividend  (num_r),
    .divisor   (div_r),
    .quotient  (quotient),
    .remainder (remainder),
    .stat      (div_stat)
  );

  // Sequencer: classify small inputs, then step through trial divisors
  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    div_nxt   = div_r;
    prime_nxt = prime_r;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          num_nxt = W'(in_ch.candidate[LW-1:0]);
          div_nxt = W'(2);
          if (num_nxt < W'(2)) begin
            prime_nxt = 1'b0;
            div_nxt   = '0;
            state_nxt = S_FIN;
          end else if (num_nxt < W'(4)) begin
            prime_nxt = 1'b1;
            div_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (div_r > quotient) begin
            prime_nxt = 1'b1;
            state_nxt = S_FIN;
          end else if (remainder == '0) begin
            prime_nxt = 1'b0;
            state_nxt = S_FIN;
          end else begin
            div_nxt   = div_r + 1'b1;
            state_nxt = S_START;
          end
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r   <= '0;
      div_r   <= '0;
      prime_r <= 1'b0;
    end else begin
      num_r   <= num_nxt;
      div_r   <= div_nxt;
      prime_r <= prime_nxt;
    end
    if (load_out) begin
      out_value_r <= TESTED_W'(num_r);
      out_prime_r <= prime_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.tested_value = out_value_r;
  assign out_ch.is_prime     = out_prime_r;

endmodule
